// ===== sv/sha1md_pkg.sv =====
// shared types, constants and codes for the sha-1 message digest block
`timescale 1ns / 1ps

package sha1md_pkg;

    // sha-1 initial chaining values, index 0 is H0
    localparam logic [4:0][31:0] H_INIT = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    // round constants
    localparam logic [31:0] K_ROUND0 = 32'h5A827999;
    localparam logic [31:0] K_ROUND1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_ROUND2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_ROUND3 = 32'hCA62C1D6;

    // padding marker byte
    localparam logic [7:0] PAD_MARK = 8'h80;

    // round and block geometry
    localparam logic [6:0] LAST_ROUND     = 7'd79;
    localparam logic [6:0] SCHED_ROUNDS   = 7'd16;
    localparam logic [6:0] ROUND_GROUP1   = 7'd20;
    localparam logic [6:0] ROUND_GROUP2   = 7'd40;
    localparam logic [6:0] ROUND_GROUP3   = 7'd60;
    localparam logic [5:0] BLOCK_LAST_POS = 6'd63;
    localparam logic [5:0] LEN_FIELD_POS  = 6'd56;
    localparam logic [2:0] LAST_WORD_IDX  = 3'd4;
    localparam logic [63:0] BITS_PER_BYTE = 64'd8;

    // input and output items
    typedef struct packed {
        logic [7:0] msg_byte;
        logic       byte_present;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_COMPRESS,
        S_CHAIN_ADD,
        S_OUTPUT
    } t_state;

    // source of the byte written into the block
    typedef enum logic [1:0] {
        SEL_INPUT,
        SEL_MARK,
        SEL_ZERO,
        SEL_LEN
    } t_byte_sel;

    // controller to datapath commands
    typedef struct packed {
        logic      load_byte;
        t_byte_sel byte_sel;
        logic      add_len;
        logic      start_work;
        logic      do_round;
        logic [6:0] round_idx;
        logic      chain_add;
        logic      chain_init;
        logic [2:0] word_idx;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic pos_last;
        logic pos_len;
    } t_dp_status;

endpackage

// ===== sv/sha1md_datapath.sv =====
// datapath: byte packing, rolling schedule, round logic, chaining words and length
`timescale 1ns / 1ps

module sha1md_datapath import sha1md_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    input  logic [7:0]  i_msg_byte,
    output t_dp_status  o_status,
    output logic [31:0] o_digest_word
);

    logic [5:0]        r_pos, n_pos;
    logic [63:0]       r_len, n_len;
    logic [23:0]       r_acc, n_acc;
    logic [15:0][31:0] r_win, n_win;
    logic [4:0][31:0]  r_work, n_work;
    logic [4:0][31:0]  r_chain, n_chain;

    logic [7:0]  byte_val;
    logic [31:0] w_sched;
    logic [31:0] w_t;
    logic [31:0] f_val;
    logic [31:0] k_val;
    logic [31:0] round_sum;
    logic [31:0] a_w, b_w, c_w, d_w, e_w;

    assign a_w = r_work[0];
    assign b_w = r_work[1];
    assign c_w = r_work[2];
    assign d_w = r_work[3];
    assign e_w = r_work[4];

    // byte source select
    always_comb begin
        unique case (i_cmd.byte_sel)
            SEL_INPUT: byte_val = i_msg_byte;
            SEL_MARK:  byte_val = PAD_MARK;
            SEL_ZERO:  byte_val = 8'h00;
            SEL_LEN:   byte_val = r_len[63:56];
            default:   byte_val = 8'h00;
        endcase
    end

    // schedule word for this round
    always_comb begin
        w_sched = r_win[13] ^ r_win[8] ^ r_win[2] ^ r_win[0];
        w_sched = {w_sched[30:0], w_sched[31]};
        w_t     = (i_cmd.round_idx < SCHED_ROUNDS) ? r_win[0] : w_sched;
    end

    // round function and constant
    always_comb begin
        if (i_cmd.round_idx < ROUND_GROUP1) begin
            f_val = (b_w & c_w) | (~b_w & d_w);
            k_val = K_ROUND0;
        end else if (i_cmd.round_idx < ROUND_GROUP2) begin
            f_val = b_w ^ c_w ^ d_w;
            k_val = K_ROUND1;
        end else if (i_cmd.round_idx < ROUND_GROUP3) begin
            f_val = (b_w & c_w) | (b_w & d_w) | (c_w & d_w);
            k_val = K_ROUND2;
        end else begin
            f_val = b_w ^ c_w ^ d_w;
            k_val = K_ROUND3;
        end
        round_sum = {a_w[26:0], a_w[31:27]} + f_val + e_w + w_t + k_val;
    end

    // next state of all datapath registers
    always_comb begin
        n_pos   = r_pos;
        n_len   = r_len;
        n_acc   = r_acc;
        n_win   = r_win;
        n_work  = r_work;
        n_chain = r_chain;

        // byte packing, a full word shifts into the schedule window
        if (i_cmd.load_byte) begin
            n_acc = {r_acc[15:0], byte_val};
            n_pos = r_pos + 6'd1;
            if (r_pos[1:0] == 2'b11) begin
                n_win = {{r_acc, byte_val}, r_win[15:1]};
            end
        end

        // bit length: count, shift out for padding, clear at the end
        priority if (i_cmd.chain_init) begin
            n_len = '0;
        end else if (i_cmd.add_len) begin
            n_len = r_len + BITS_PER_BYTE;
        end else if (i_cmd.load_byte && i_cmd.byte_sel == SEL_LEN) begin
            n_len = {r_len[55:0], 8'h00};
        end

        // one compression round, window rolls by one word
        if (i_cmd.do_round) begin
            n_win     = {w_t, r_win[15:1]};
            n_work[4] = d_w;
            n_work[3] = c_w;
            n_work[2] = {b_w[1:0], b_w[31:2]};
            n_work[1] = a_w;
            n_work[0] = round_sum;
        end else if (i_cmd.start_work) begin
            n_work = r_chain;
        end

        // chaining words
        priority if (i_cmd.chain_init) begin
            n_chain = H_INIT;
        end else if (i_cmd.chain_add) begin
            for (int i = 0; i < 5; i++) begin
                n_chain[i] = r_chain[i] + r_work[i];
            end
        end
    end

    // control-like state under reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_len   <= '0;
            r_work  <= '0;
            r_chain <= H_INIT;
        end else begin
            r_pos   <= n_pos;
            r_len   <= n_len;
            r_work  <= n_work;
            r_chain <= n_chain;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_win <= n_win;
    end

    assign o_status.pos_last = (r_pos == BLOCK_LAST_POS);
    assign o_status.pos_len  = (r_pos == LEN_FIELD_POS);

    // digest word select
    always_comb begin
        unique case (i_cmd.word_idx)
            3'd0:    o_digest_word = r_chain[0];
            3'd1:    o_digest_word = r_chain[1];
            3'd2:    o_digest_word = r_chain[2];
            3'd3:    o_digest_word = r_chain[3];
            3'd4:    o_digest_word = r_chain[4];
            default: o_digest_word = r_chain[0];
        endcase
    end

endmodule

// ===== sv/sha1md_ctrl.sv =====
// controller: sequences byte loading, padding, compression and digest output
`timescale 1ns / 1ps

module sha1md_ctrl import sha1md_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_in_item   i_in_item,
    output logic       o_in_stall,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state     r_state, n_state;
    logic [6:0] r_round, n_round;
    logic [2:0] r_idx, n_idx;
    logic       r_pad, n_pad;
    logic       r_mark, n_mark;
    logic       r_lenph, n_lenph;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_round <= '0;
            r_idx   <= '0;
            r_pad   <= 1'b0;
            r_mark  <= 1'b0;
            r_lenph <= 1'b0;
        end else begin
            r_state <= n_state;
            r_round <= n_round;
            r_idx   <= n_idx;
            r_pad   <= n_pad;
            r_mark  <= n_mark;
            r_lenph <= n_lenph;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_round = r_round;
        n_idx   = r_idx;
        n_pad   = r_pad;
        n_mark  = r_mark;
        n_lenph = r_lenph;

        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;

        o_cmd            = '0;
        o_cmd.byte_sel   = SEL_INPUT;
        o_cmd.round_idx  = r_round;
        o_cmd.word_idx   = r_idx;

        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (i_in_item.byte_present) begin
                        o_cmd.load_byte = 1'b1;
                        o_cmd.add_len   = 1'b1;
                        if (i_in_item.end_of_message) begin
                            n_pad = 1'b1;
                        end
                        if (i_status.pos_last) begin
                            o_cmd.start_work = 1'b1;
                            n_state          = S_COMPRESS;
                        end else if (i_in_item.end_of_message) begin
                            n_state = S_PAD;
                        end
                    end else if (i_in_item.end_of_message) begin
                        n_pad   = 1'b1;
                        n_state = S_PAD;
                    end
                end
            end

            // one padding byte per cycle
            S_PAD: begin
                o_cmd.load_byte = 1'b1;
                if (!r_mark) begin
                    o_cmd.byte_sel = SEL_MARK;
                    n_mark         = 1'b1;
                end else if (r_lenph || i_status.pos_len) begin
                    o_cmd.byte_sel = SEL_LEN;
                    n_lenph        = 1'b1;
                end else begin
                    o_cmd.byte_sel = SEL_ZERO;
                end
                if (i_status.pos_last) begin
                    o_cmd.start_work = 1'b1;
                    n_state          = S_COMPRESS;
                end
            end

            // eighty rounds, one per cycle
            S_COMPRESS: begin
                o_cmd.do_round = 1'b1;
                if (r_round == LAST_ROUND) begin
                    n_round = '0;
                    n_state = S_CHAIN_ADD;
                end else begin
                    n_round = r_round + 7'd1;
                end
            end

            S_CHAIN_ADD: begin
                o_cmd.chain_add = 1'b1;
                priority if (r_lenph) begin
                    n_state = S_OUTPUT;
                end else if (r_pad) begin
                    n_state = S_PAD;
                end else begin
                    n_state = S_IDLE;
                end
            end

            // five digest word transfers
            S_OUTPUT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    if (r_idx == LAST_WORD_IDX) begin
                        o_cmd.chain_init = 1'b1;
                        n_idx   = '0;
                        n_pad   = 1'b0;
                        n_mark  = 1'b0;
                        n_lenph = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/sha1_message_digest.sv =====
// top level of the streaming sha-1 message digest block
`timescale 1ns / 1ps

// Streaming SHA-1: message bytes enter one per input transfer, most significant
// first; an item with end_of_message closes the message (with or without a last
// byte) and the block then gives five result transfers, H0 through H4, with
// last_word set on H4, and returns to the initial chaining values. A byte that
// does not complete a 64-byte block does not stall the input; the byte that
// completes a block holds off the input while the rounds run, one round per
// cycle through a single round adder, and then while the chaining words are
// added. Closing a message pads one byte per cycle (up to two blocks of
// padding, each followed by its compression), then offers the five digest
// words, one per cycle while the output is not stalled. Input is stalled
// whenever the block is not waiting for a byte.

module sha1_message_digest import sha1md_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_dp_cmd     dp_cmd;
    t_dp_status  dp_status;
    logic [31:0] digest_word;

    sha1md_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    sha1md_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .i_msg_byte    (i_in_item.msg_byte),
        .o_status      (dp_status),
        .o_digest_word (digest_word)
    );

    // result item, held steady from registers while stalled
    assign o_out_item.digest_word = digest_word;
    assign o_out_item.word_index  = dp_cmd.word_idx;
    assign o_out_item.last_word   = (dp_cmd.word_idx == LAST_WORD_IDX);

endmodule

// ===== dv/tb_top.sv =====
// self-checking testbench for the streaming sha-1 message digest block
`timescale 1ns / 1ps

module tb_top;
    import sha1md_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 300;
    localparam int RANDOM_BYTES = 225;
    localparam int MIN_MESSAGES = 6;

    // one queued input transfer, optionally held until all digests are out
    typedef struct {
        t_in_item item;
        bit       wait_drain;
    } t_pending;

    logic      clk;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    sha1_message_digest dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item (out_item)
    );

    // clock
    always begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // predicted sha-1 state
    logic [31:0] chain_h [5];
    logic [31:0] sched_w [16];
    logic [5:0]  fill_pos;
    logic [63:0] msg_bits;

    t_out_item digest_words_due [$];
    t_pending  stim_q [$];
    int        words_outstanding = 0;

    int mismatches = 0;
    int msgs_closed = 0;
    int bytes_taken = 0;
    int blocks_done = 0;
    int words_checked = 0;
    int items_queued = 0;
    int msgs_queued = 0;

    task automatic restart_digest();
        int i;
        for (i = 0; i < 5; i++)
            chain_h[i] = H_INIT[i];
        fill_pos = '0;
        msg_bits = '0;
    endtask

    // 80-round compression over the current 16-word block
    task automatic compress_block();
        logic [31:0] a, b, c, d, e, f, k, w, t;
        int r;
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (r = 0; r < 80; r++) begin
            if (r < 16) begin
                w = sched_w[r];
            end else begin
                w = sched_w[(r - 3) % 16] ^ sched_w[(r - 8) % 16] ^
                    sched_w[(r - 14) % 16] ^ sched_w[r % 16];
                w = {w[30:0], w[31]};
                sched_w[r % 16] = w;
            end
            if (r < 20) begin
                f = (b & c) | (~b & d);
                k = K_ROUND0;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = K_ROUND1;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K_ROUND2;
            end else begin
                f = b ^ c ^ d;
                k = K_ROUND3;
            end
            t = {a[26:0], a[31:27]} + f + e + w + k;
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
        blocks_done++;
    endtask

    // big-endian packing into the schedule words
    task automatic put_block_byte(input logic [7:0] v);
        if (fill_pos[1:0] == 2'd0)
            sched_w[fill_pos[5:2]] = '0;
        sched_w[fill_pos[5:2]][8 * (3 - int'(fill_pos[1:0])) +: 8] = v;
        if (fill_pos == BLOCK_LAST_POS) begin
            fill_pos = '0;
            compress_block();
        end else begin
            fill_pos++;
        end
    endtask

    // work out the digest words that one accepted transfer produces
    task automatic absorb_item(input t_in_item it);
        logic [63:0] len;
        t_out_item dw;
        int i;
        if (it.byte_present) begin
            put_block_byte(it.msg_byte);
            msg_bits += BITS_PER_BYTE;
            bytes_taken++;
        end
        if (it.end_of_message) begin
            len = msg_bits;
            put_block_byte(PAD_MARK);
            while (fill_pos != LEN_FIELD_POS)
                put_block_byte(8'h00);
            for (i = 7; i >= 0; i--)
                put_block_byte(len[8 * i +: 8]);
            for (i = 0; i < 5; i++) begin
                dw.digest_word = chain_h[i];
                dw.word_index  = 3'(i);
                dw.last_word   = (3'(i) == LAST_WORD_IDX);
                digest_words_due.insert(digest_words_due.size(), dw);
            end
            restart_digest();
            msgs_closed++;
        end
    endtask

    function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 40)
                $display("%0t: %s mismatch: expected %08h, actual %08h",
                         $time, what, want, got);
        end
    endfunction

    // stimulus helpers
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic queue_item(input logic [7:0] v, input logic present, input logic eom,
                              input bit wait_drain);
        t_pending p;
        p.item.msg_byte = v;
        p.item.byte_present = present;
        p.item.end_of_message = eom;
        p.wait_drain = wait_drain;
        stim_q.insert(stim_q.size(), p);
        if (present || eom)
            items_queued++;
    endtask

    task automatic queue_message(input int n, input bit sep_close, input bit wait_drain,
                                 input bit noisy);
        int i;
        bit first;
        first = wait_drain;
        if (n == 0)
            sep_close = 1'b1;
        for (i = 0; i < n; i++) begin
            if (noisy && $urandom_range(0, 15) == 0) begin
                queue_item(pick_byte(), 1'b0, 1'b0, first);
                first = 1'b0;
            end
            queue_item(pick_byte(), 1'b1, !sep_close && i == n - 1, first);
            first = 1'b0;
        end
        if (sep_close)
            queue_item(pick_byte(), 1'b0, 1'b1, first);
        msgs_queued++;
    endtask

    // driver: bursts of transfers with random gaps
    int burst_left;
    int gap_left;

    always @(posedge clk) begin : drive_in
        t_pending nxt;
        if (!rst_n) begin
            in_valid <= 1'b0;
            burst_left <= 4;
            gap_left <= 0;
        end else if (!in_valid || !in_stall) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end else if (stim_q.size() != 0 &&
                         (!stim_q[0].wait_drain || (!in_valid && words_outstanding == 0))) begin
                nxt = stim_q.pop_front();
                in_valid <= 1'b1;
                in_item <= nxt.item;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver backpressure: free-running, random and periodic phases
    int stall_mode = 0;
    int stall_phase_left = 0;
    logic [2:0] stall_tick = '0;

    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            stall_tick <= stall_tick + 3'd1;
            if (stall_phase_left == 0) begin
                stall_mode <= $urandom_range(0, 2);
                stall_phase_left <= $urandom_range(20, 150);
            end else begin
                stall_phase_left <= stall_phase_left - 1;
            end
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 2) == 0);
                default: out_stall <= (stall_tick < 3'd5);
            endcase
        end
    end

    // monitor: predict on input transfers, compare on output transfers
    always @(posedge clk) begin : watch_io
        t_out_item want;
        if (rst_n) begin
            if (in_valid && !in_stall)
                absorb_item(in_item);
            if (out_valid && !out_stall) begin
                if (digest_words_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 40)
                        $display("%0t: digest word mismatch: expected none, actual %08h idx %0d",
                                 $time, out_item.digest_word, out_item.word_index);
                end else begin
                    want = digest_words_due.pop_front();
                    check_field("digest_word", want.digest_word, out_item.digest_word);
                    check_field("word_index", 32'(want.word_index), 32'(out_item.word_index));
                    check_field("last_word", 32'(want.last_word), 32'(out_item.last_word));
                    words_checked++;
                end
            end
            words_outstanding <= digest_words_due.size();
        end
    end

    // watchdog on cycles without any transfer
    int idle_cycles = 0;

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // stimulus and end of run
    initial begin : stimulus
        int n;
        int r;
        int edge_lens [6];
        edge_lens = '{55, 56, 63, 64, 119, 120};
        restart_digest();

        // directed: empty message, one-byte messages at the byte extremes
        queue_item(8'hFF, 1'b0, 1'b1, 1'b0);
        queue_item(8'h00, 1'b1, 1'b1, 1'b0);
        queue_item(8'hFF, 1'b1, 1'b1, 1'b0);
        // "abc" closed by an item carrying no byte
        queue_item(8'h61, 1'b1, 1'b0, 1'b0);
        queue_item(8'h62, 1'b1, 1'b0, 1'b0);
        queue_item(8'h63, 1'b1, 1'b0, 1'b0);
        queue_item(8'hA5, 1'b0, 1'b1, 1'b0);
        // ignored item between messages, then a message after a full drain
        queue_item(8'hFF, 1'b0, 1'b0, 1'b0);
        queue_item(8'h80, 1'b1, 1'b0, 1'b1);
        queue_item(8'h5A, 1'b0, 1'b1, 1'b0);
        // ignored item in the middle of a message
        queue_item(8'h01, 1'b1, 1'b0, 1'b0);
        queue_item(8'h00, 1'b0, 1'b0, 1'b0);
        queue_item(8'h7F, 1'b1, 1'b1, 1'b0);

        // random messages: mostly short, some on the padding boundaries
        n = items_queued;
        items_queued = 0;
        queue_message($urandom_range(1, 8), $urandom_range(0, 1), 1'b1, 1'b1);
        while (items_queued < RANDOM_BYTES || msgs_queued < MIN_MESSAGES) begin
            r = $urandom_range(0, 9);
            if (r < 6)
                n = $urandom_range(0, 12);
            else if (r < 9)
                n = edge_lens[$urandom_range(0, 5)];
            else
                n = $urandom_range(8, 70);
            // keep the total close to the planned item count
            if (items_queued + n > RANDOM_BYTES)
                n = (items_queued < RANDOM_BYTES) ? RANDOM_BYTES - items_queued : 0;
            queue_message(n, $urandom_range(0, 1), $urandom_range(0, 5) == 0, 1'b1);
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (stim_q.size() != 0 || in_valid)
            @(negedge clk);
        while (digest_words_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("summary: %0d messages digested from %0d bytes, %0d blocks compressed",
                 msgs_closed, bytes_taken, blocks_done);
        $display("summary: %0d digest words compared under sender gaps and receiver stalls",
                 words_checked);
        if (mismatches == 0 && digest_words_due.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
